### hdl/tts_pkg.sv
// Shared types and constants of the task table scheduler.
package tts_pkg;

    localparam int IDX_MAX_W = 6;

    localparam logic [2:0] CMD_CREATE = 3'd0;
    localparam logic [2:0] CMD_DELAY  = 3'd1;
    localparam logic [2:0] CMD_YIELD  = 3'd2;
    localparam logic [2:0] CMD_TICK   = 3'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    localparam logic [1:0] TS_READY   = 2'd0;
    localparam logic [1:0] TS_RUNNING = 2'd1;
    localparam logic [1:0] TS_WAITING = 2'd2;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_CREATE,
        OP_DELAY,
        OP_YIELD,
        OP_TICK,
        OP_RUN
    } t_cell_op;

    typedef struct packed {
        logic [2:0]  command;
        logic [7:0]  task_id;
        logic [7:0]  priority_req;
        logic [15:0] delay_ticks;
    } t_in_item;

    typedef struct packed {
        logic [1:0] status;
        logic [2:0] running_index;
        logic [7:0] running_id;
    } t_out_item;

    typedef struct packed {
        t_cell_op    op;
        logic [7:0]  task_id;
        logic [7:0]  priority_req;
        logic [15:0] delay_ticks;
    } t_cell_cmd;

    // search carry handed from cell to cell
    typedef struct packed {
        logic                 hi_found;
        logic [IDX_MAX_W-1:0] hi_idx;
        logic [7:0]           hi_id;
        logic                 lo_found;
        logic [IDX_MAX_W-1:0] lo_idx;
        logic [7:0]           lo_id;
        logic                 pr_found;
        logic [7:0]           pr_prio;
        logic [IDX_MAX_W-1:0] pr_idx;
        logic [7:0]           pr_id;
        logic [7:0]           cur_id;
    } t_chain;

endpackage

### hdl/tts_cell.sv
// One task table entry with its stage of the registered selection chain.
module tts_cell #(
    parameter int TABLE_DEPTH = 8,
    parameter int DELAY_BITS  = 16,
    parameter int CELL_IDX    = 0,
    localparam int IDX_W = $clog2(TABLE_DEPTH),
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1)
) (
    input  logic               i_clk,
    input  tts_pkg::t_cell_cmd i_cmd,
    input  logic [IDX_W-1:0]   i_sel,
    input  logic [IDX_W-1:0]   i_cur,
    input  logic [CNT_W-1:0]   i_count,
    input  tts_pkg::t_chain    i_carry,
    output tts_pkg::t_chain    o_carry
);

    logic [7:0]            r_id;
    logic [7:0]            r_prio;
    logic [DELAY_BITS-1:0] r_delay;
    logic [1:0]            r_state;
    tts_pkg::t_chain       r_carry;

    logic [7:0]            n_id;
    logic [7:0]            n_prio;
    logic [DELAY_BITS-1:0] n_delay;
    logic [1:0]            n_state;
    tts_pkg::t_chain       n_carry;

    logic w_sel;
    logic w_cur;
    logic w_after;
    logic w_in_range;
    logic w_elig;

    assign w_sel      = (i_sel == IDX_W'(CELL_IDX));
    assign w_cur      = (i_cur == IDX_W'(CELL_IDX));
    assign w_after    = (IDX_W'(CELL_IDX) > i_cur);
    assign w_in_range = (CNT_W'(CELL_IDX) < i_count);
    assign w_elig     = w_in_range && (r_state == tts_pkg::TS_READY);

    always_comb begin
        n_id    = r_id;
        n_prio  = r_prio;
        n_delay = r_delay;
        n_state = r_state;
        case (i_cmd.op)
            tts_pkg::OP_CREATE: begin
                if (w_sel) begin
                    n_id    = i_cmd.task_id;
                    n_prio  = i_cmd.priority_req;
                    n_delay = '0;
                    n_state = tts_pkg::TS_READY;
                end
            end
            tts_pkg::OP_DELAY: begin
                if (w_sel) begin
                    n_delay = DELAY_BITS'(i_cmd.delay_ticks);
                    if (r_state == tts_pkg::TS_RUNNING) begin
                        n_state = tts_pkg::TS_WAITING;
                    end
                end
            end
            tts_pkg::OP_YIELD: begin
                if (w_sel && r_state == tts_pkg::TS_RUNNING) begin
                    n_state = tts_pkg::TS_READY;
                end
            end
            tts_pkg::OP_TICK: begin
                if (w_in_range && r_state == tts_pkg::TS_WAITING && r_delay != '0) begin
                    n_delay = r_delay - 1'b1;
                    if (r_delay == DELAY_BITS'(1)) begin
                        n_state = tts_pkg::TS_READY;
                    end
                end
            end
            tts_pkg::OP_RUN: begin
                if (w_sel) begin
                    n_state = tts_pkg::TS_RUNNING;
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_carry = i_carry;
        if (w_elig && w_after && !i_carry.hi_found) begin
            n_carry.hi_found = 1'b1;
            n_carry.hi_idx   = tts_pkg::IDX_MAX_W'(CELL_IDX);
            n_carry.hi_id    = r_id;
        end
        if (w_elig && !w_after && !i_carry.lo_found) begin
            n_carry.lo_found = 1'b1;
            n_carry.lo_idx   = tts_pkg::IDX_MAX_W'(CELL_IDX);
            n_carry.lo_id    = r_id;
        end
        if (w_elig && (!i_carry.pr_found || r_prio > i_carry.pr_prio)) begin
            n_carry.pr_found = 1'b1;
            n_carry.pr_prio  = r_prio;
            n_carry.pr_idx   = tts_pkg::IDX_MAX_W'(CELL_IDX);
            n_carry.pr_id    = r_id;
        end
        if (w_cur) begin
            n_carry.cur_id = r_id;
        end
    end

    always_ff @(posedge i_clk) begin
        r_id    <= n_id;
        r_prio  <= n_prio;
        r_delay <= n_delay;
        r_state <= n_state;
        r_carry <= n_carry;
    end

    assign o_carry = r_carry;

endmodule

### hdl/task_table_scheduler.sv
// Task table scheduler: command sequencing and the row of table cells.
//
// Usage: input items (command, task id, priority, delay) arrive on the
// i_in_valid / o_in_ready channel; one result item (status, running index,
// running id) leaves on o_out_valid / i_out_ready for every input item.
// The one-bit scheduling mode is written on the i_cfg_valid / o_cfg_ready
// channel; the user must write it only while no item is in flight, as the
// block itself does not enforce this. 0 selects round robin, 1 selects the
// highest-priority ready task. The command acts on the table at the accept
// edge, the selection carry then ripples through TABLE_DEPTH registered
// cells while the block waits, and the result is then loaded into the
// output register. One item is in work at a time: no new item is accepted
// until the last one has left for the output register.
// The output register parts the two sides: a new item is accepted while a
// result still waits. If the receiver stalls, the next result is held back
// in the block until the output register frees up.
// Reset empties the table, sets the running index to zero and the mode to
// round robin; table entries are undefined until created.
module task_table_scheduler #(
    parameter int TABLE_DEPTH = 8,
    parameter int DELAY_BITS  = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  tts_pkg::t_in_item i_in,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output tts_pkg::t_out_item o_out,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic              i_cfg_data
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_WAIT,
        S_DONE
    } t_state;

    t_state             r_state;
    logic [IDX_W-1:0]   r_wait;
    logic [CNT_W-1:0]   r_count;
    logic [IDX_W-1:0]   r_cur;
    logic               r_mode;
    logic               r_disp;
    logic [1:0]         r_status;
    logic               r_out_valid;
    tts_pkg::t_out_item r_out;

    tts_pkg::t_cell_cmd w_cmd;
    logic [IDX_W-1:0]   w_sel;
    tts_pkg::t_chain    w_carry [TABLE_DEPTH+1];
    tts_pkg::t_chain    w_last;

    logic               w_accept;
    logic               w_finish;
    logic               w_full;
    logic               w_empty;
    logic               w_found;
    logic [IDX_W-1:0]   w_chosen_idx;
    logic [7:0]         w_chosen_id;
    logic [IDX_W-1:0]   n_cur;
    logic [7:0]         n_id;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_finish    = (r_state == S_DONE) && (!r_out_valid || i_out_ready);
    assign w_full      = (r_count == CNT_W'(TABLE_DEPTH));
    assign w_empty     = (r_count == '0);
    assign w_last      = w_carry[TABLE_DEPTH];

    // final pick from the end of the chain
    always_comb begin
        if (r_mode) begin
            w_found      = w_last.pr_found;
            w_chosen_idx = w_last.pr_idx[IDX_W-1:0];
            w_chosen_id  = w_last.pr_id;
        end else if (w_last.hi_found) begin
            w_found      = 1'b1;
            w_chosen_idx = w_last.hi_idx[IDX_W-1:0];
            w_chosen_id  = w_last.hi_id;
        end else begin
            w_found      = w_last.lo_found;
            w_chosen_idx = w_last.lo_idx[IDX_W-1:0];
            w_chosen_id  = w_last.lo_id;
        end
        if (r_disp && w_found) begin
            n_cur = w_chosen_idx;
            n_id  = w_chosen_id;
        end else begin
            n_cur = r_cur;
            n_id  = w_last.cur_id;
        end
        if (w_empty) begin
            n_id = '0;
        end
    end

    always_comb begin
        w_cmd.op           = tts_pkg::OP_NONE;
        w_cmd.task_id      = i_in.task_id;
        w_cmd.priority_req = i_in.priority_req;
        w_cmd.delay_ticks  = i_in.delay_ticks;
        w_sel              = r_cur;
        if (w_accept) begin
            case (i_in.command)
                tts_pkg::CMD_CREATE: begin
                    if (!w_full) begin
                        w_cmd.op = tts_pkg::OP_CREATE;
                        w_sel    = r_count[IDX_W-1:0];
                    end
                end
                tts_pkg::CMD_DELAY: begin
                    if (!w_empty) begin
                        w_cmd.op = tts_pkg::OP_DELAY;
                    end
                end
                tts_pkg::CMD_YIELD: begin
                    if (!w_empty) begin
                        w_cmd.op = tts_pkg::OP_YIELD;
                    end
                end
                tts_pkg::CMD_TICK: begin
                    w_cmd.op = tts_pkg::OP_TICK;
                end
                default: begin
                end
            endcase
        end else if (w_finish && r_disp && w_found) begin
            w_cmd.op = tts_pkg::OP_RUN;
            w_sel    = w_chosen_idx;
        end
    end

    assign w_carry[0] = '0;

    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
        tts_cell #(
            .TABLE_DEPTH (TABLE_DEPTH),
            .DELAY_BITS  (DELAY_BITS),
            .CELL_IDX    (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_cmd   (w_cmd),
            .i_sel   (w_sel),
            .i_cur   (r_cur),
            .i_count (r_count),
            .i_carry (w_carry[g]),
            .o_carry (w_carry[g+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_wait      <= '0;
            r_count     <= '0;
            r_cur       <= '0;
            r_mode      <= 1'b0;
            r_disp      <= 1'b0;
            r_status    <= tts_pkg::ST_OK;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_mode <= i_cfg_data;
            end
            if (w_finish) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_state  <= S_WAIT;
                        r_wait   <= '0;
                        case (i_in.command)
                            tts_pkg::CMD_CREATE: begin
                                r_disp <= 1'b0;
                                if (w_full) begin
                                    r_status <= tts_pkg::ST_FULL;
                                end else begin
                                    r_status <= tts_pkg::ST_OK;
                                    r_count  <= r_count + 1'b1;
                                end
                            end
                            tts_pkg::CMD_DELAY, tts_pkg::CMD_YIELD: begin
                                if (w_empty) begin
                                    r_status <= tts_pkg::ST_EMPTY;
                                    r_disp   <= 1'b0;
                                end else begin
                                    r_status <= tts_pkg::ST_OK;
                                    r_disp   <= 1'b1;
                                end
                            end
                            default: begin
                                r_status <= tts_pkg::ST_OK;
                                r_disp   <= 1'b0;
                            end
                        endcase
                    end
                end
                S_WAIT: begin
                    r_wait <= r_wait + 1'b1;
                    if (r_wait == IDX_W'(TABLE_DEPTH - 1)) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (w_finish) begin
                        r_state             <= S_IDLE;
                        r_cur               <= n_cur;
                        r_out.status        <= r_status;
                        r_out.running_index <= 3'(n_cur);
                        r_out.running_id    <= n_id;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(TABLE_DEPTH))
        else $error("task count beyond table depth");

    a_cur_in_table: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != '0) |-> (CNT_W'(r_cur) < r_count))
        else $error("running index outside filled table");

    a_accept_starts_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == S_WAIT) && !o_in_ready)
        else $error("accepted item did not start the chain wait");

    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> ($past(r_state) == S_DONE))
        else $error("result loaded outside the finish step");

endmodule
